FILE: sv/lidar_beam_to_grid_cell_top_macros.svh
// Assertion macros shared by the checker of the beam-to-grid block.
`ifndef LIDAR_BEAM_TO_GRID_CELL_TOP_MACROS_SVH
`define LIDAR_BEAM_TO_GRID_CELL_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBG_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbg assertion failed");

// Next-cycle implication, disabled during reset.
`define LBG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbg assertion failed");

`endif

FILE: sv/lbg_pkg.sv
// Shared constants, tables and types of the beam-to-grid block.
`default_nettype none
package lbg_pkg;

  localparam int GRID_DIM      = 1024;
  localparam int MAX_BEAMS     = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int ROW_MARGIN    = 30;

  localparam int ATAN_ENTRIES   = 24;
  localparam int GAIN_Q16       = 39796;
  localparam int CELL_DIV       = 10 * 65536;
  localparam int RANGE_GUARD_MM = 100;
  localparam int FOLD_LIMIT     = 16384;
  localparam int HALF_TURN      = 32768;
  localparam int ROW_TOP        = GRID_DIM - ROW_MARGIN - 1;

  // datapath widths: vector in Q16 mm with CORDIC growth, angle 2^32 per turn
  localparam int XW = 36;
  localparam int ZW = 33;
  localparam int CELL_W = 10;

  localparam int FRONT_STAGES = 2;
  localparam int CELL_STAGES  = 4;
  localparam int PIPE_STAGES  = FRONT_STAGES + CORDIC_STAGES + CELL_STAGES;

  localparam int CFG_IW = 4;
  localparam int CFG_DW = 16;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ANGLE_START       = 4'd0,
    CFG_ANGLE_STEP        = 4'd1,
    CFG_RANGE_FLOOR_MM    = 4'd2,
    CFG_RANGE_CEILING_MM  = 4'd3,
    CFG_ORIGIN_COL        = 4'd4,
    CFG_ORIGIN_ROW_OFFSET = 4'd5,
    CFG_NEAR_LIMIT        = 4'd6,
    CFG_FAR_LIMIT         = 4'd7
  } cfg_reg_t;

  localparam logic signed [ZW-1:0] ATAN [ATAN_ENTRIES] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  typedef struct packed {
    logic [15:0] range_mm;
    logic [9:0]  beam_index;
    logic        scan_end;
  } beam_t;

  typedef struct packed {
    logic              hit;
    logic [CELL_W-1:0] cell_col;
    logic [CELL_W-1:0] cell_row;
    logic              scan_done;
  } cell_t;

  typedef struct packed {
    logic [15:0]        angle_start;
    logic [15:0]        angle_step;
    logic [15:0]        range_floor_mm;
    logic [15:0]        range_ceiling_mm;
    logic [9:0]         origin_col;
    logic signed [10:0] origin_row_offset;
    logic [9:0]         near_limit;
    logic [10:0]        far_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 ok;
    logic                 scan_end;
  } rot_t;

endpackage
`default_nettype wire

FILE: sv/lbg_front.sv
// Front stages: range gate, beam angle, quadrant fold and start vector.
`default_nettype none
module lbg_front (
  input  logic                              clk,
  input  logic                              rst,
  input  lbg_pkg::cfg_t                     cfg,
  input  logic [lbg_pkg::FRONT_STAGES-1:0]  load,
  input  logic                              in_valid,
  input  lbg_pkg::beam_t                    in_item,
  output logic [lbg_pkg::FRONT_STAGES-1:0]  valid,
  output lbg_pkg::rot_t                     out_rot
);
  import lbg_pkg::*;

  // stage A
  logic [15:0] a_range;
  logic [15:0] a_mul;
  logic        a_ok;
  logic        a_end;

  logic [25:0]        prod;
  logic signed [17:0] ceil_lim;
  logic               range_ok;

  always_comb begin
    prod     = 26'(in_item.beam_index) * 26'(cfg.angle_step);
    ceil_lim = $signed({2'b00, cfg.range_ceiling_mm}) - 18'(RANGE_GUARD_MM);
    range_ok = (in_item.range_mm > cfg.range_floor_mm) &&
               ($signed({2'b00, in_item.range_mm}) < ceil_lim) &&
               (32'(in_item.beam_index) < MAX_BEAMS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (load[0]) begin
      valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a_range <= in_item.range_mm;
      a_mul   <= prod[15:0];
      a_ok    <= range_ok;
      a_end   <= in_item.scan_end;
    end
  end

  // stage B
  logic [15:0]          a16;
  logic signed [16:0]   z16;
  logic                 fold;
  logic [31:0]          mag;
  rot_t                 rot_next;

  always_comb begin
    a16  = cfg.angle_start + a_mul;
    fold = 1'b0;
    z16  = 17'($signed(a16));
    // fold beyond a quarter turn back by a half turn
    if ($signed(a16) > 16'(FOLD_LIMIT)) begin
      z16  = 17'($signed(a16)) - 17'(HALF_TURN);
      fold = 1'b1;
    end else if ($signed(a16) < -16'(FOLD_LIMIT)) begin
      z16  = 17'($signed(a16)) + 17'(HALF_TURN);
      fold = 1'b1;
    end
    mag = 32'(a_range) * 32'(GAIN_Q16);
    rot_next.x        = fold ? -$signed(XW'(mag)) : $signed(XW'(mag));
    rot_next.y        = '0;
    rot_next.z        = {z16, 16'b0};
    rot_next.ok       = a_ok;
    rot_next.scan_end = a_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[1] <= 1'b0;
    end else if (load[1]) begin
      valid[1] <= valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      out_rot <= rot_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/lbg_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
`default_nettype none
module lbg_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lbg_pkg::CORDIC_STAGES-1:0]  load,
  input  logic                               in_valid,
  input  lbg_pkg::rot_t                      in_rot,
  output logic [lbg_pkg::CORDIC_STAGES-1:0]  valid,
  output lbg_pkg::rot_t                      out_rot
);
  import lbg_pkg::*;

  rot_t stage [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    rot_t                 prev;
    logic                 prev_v;
    rot_t                 nxt;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    if (i == 0) begin : g_first
      assign prev   = in_rot;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = stage[i-1];
      assign prev_v = valid[i-1];
    end

    always_comb begin
      dx  = $signed(prev.y) >>> i;
      dy  = $signed(prev.x) >>> i;
      nxt = prev;
      if ($signed(prev.z) >= 0) begin
        nxt.x = $signed(prev.x) - dx;
        nxt.y = $signed(prev.y) + dy;
        nxt.z = $signed(prev.z) - ATAN[i];
      end else begin
        nxt.x = $signed(prev.x) + dx;
        nxt.y = $signed(prev.y) - dy;
        nxt.z = $signed(prev.z) + ATAN[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (load[i]) begin
        valid[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (load[i]) begin
        stage[i] <= nxt;
      end
    end
  end

  assign out_rot = stage[CORDIC_STAGES-1];

endmodule
`default_nettype wire

FILE: sv/lbg_cell.sv
// Back stages: scale to centimetre cells, bounds checks, row mapping.
`default_nettype none
module lbg_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  lbg_pkg::cfg_t                    cfg,
  input  logic [lbg_pkg::CELL_STAGES-1:0]  load,
  input  logic                             in_valid,
  input  lbg_pkg::rot_t                    in_rot,
  output logic [lbg_pkg::CELL_STAGES-1:0]  valid,
  output lbg_pkg::cell_t                   out_item
);
  import lbg_pkg::*;

  localparam int NW = XW + 1;          // numerator with origin term
  localparam int VW = NW - 17;         // magnitude after dropping Q16 fraction
  localparam int QW = VW - 3;          // quotient by ten
  localparam int SW = QW + 2;          // signed cell coordinate
  localparam int RK = VW + 5;          // reciprocal shift
  localparam int RW = RK - 3;          // reciprocal width
  localparam logic [RW-1:0] RECIP10 = RW'((64'(1) << RK) / 64'(10));

  typedef struct packed {
    logic          neg_c;
    logic          neg_f;
    logic [VW-1:0] vc;
    logic [VW-1:0] vf;
    logic          ok;
    logic          scan_end;
  } mag_t;

  typedef struct packed {
    logic          neg_c;
    logic          neg_f;
    logic [VW-1:0] vc;
    logic [VW-1:0] vf;
    logic [QW-1:0] qc;
    logic [QW-1:0] qf;
    logic          ok;
    logic          scan_end;
  } quot_t;

  typedef struct packed {
    logic signed [SW-1:0] cx;
    logic signed [SW-1:0] fy;
    logic                 ok;
    logic                 scan_end;
  } coord_t;

  // the estimate is low by at most one; one compare fixes it
  function automatic logic [QW-1:0] fix_q(input logic [VW-1:0] v, input logic [QW-1:0] q0);
    logic [VW-1:0] rem;
    rem = v - VW'(q0) * VW'(10);
    return (rem >= VW'(10)) ? q0 + QW'(1) : q0;
  endfunction

  // stage 1: numerators, sign and magnitude in whole millimetres
  logic signed [NW-1:0] col_base, row_base, ncol, nfy, acol, afy;
  mag_t                 m_next, m_r;

  always_comb begin
    col_base = $signed(NW'(cfg.origin_col) * NW'(CELL_DIV));
    row_base = NW'(cfg.origin_row_offset) * NW'(CELL_DIV);
    ncol     = col_base - NW'($signed(in_rot.y));
    nfy      = row_base + NW'($signed(in_rot.x));
    acol     = ncol[NW-1] ? -ncol : ncol;
    afy      = nfy[NW-1] ? -nfy : nfy;
    m_next.neg_c    = ncol[NW-1];
    m_next.neg_f    = nfy[NW-1];
    m_next.vc       = acol[NW-2:16];
    m_next.vf       = afy[NW-2:16];
    m_next.ok       = in_rot.ok;
    m_next.scan_end = in_rot.scan_end;
  end

  // stage 2: reciprocal multiply
  logic [VW+RW-1:0] pc, pf;
  quot_t            q_next, q_r;

  always_comb begin
    pc = (VW+RW)'(m_r.vc) * (VW+RW)'(RECIP10);
    pf = (VW+RW)'(m_r.vf) * (VW+RW)'(RECIP10);
    q_next.neg_c    = m_r.neg_c;
    q_next.neg_f    = m_r.neg_f;
    q_next.vc       = m_r.vc;
    q_next.vf       = m_r.vf;
    q_next.qc       = pc[RK +: QW];
    q_next.qf       = pf[RK +: QW];
    q_next.ok       = m_r.ok;
    q_next.scan_end = m_r.scan_end;
  end

  // stage 3: correction and sign, truncating toward zero
  logic [QW-1:0]        qc, qf;
  coord_t               c_next, c_r;

  always_comb begin
    qc = fix_q(q_r.vc, q_r.qc);
    qf = fix_q(q_r.vf, q_r.qf);
    c_next.cx       = q_r.neg_c ? -$signed(SW'(qc)) : $signed(SW'(qc));
    c_next.fy       = q_r.neg_f ? -$signed(SW'(qf)) : $signed(SW'(qf));
    c_next.ok       = q_r.ok;
    c_next.scan_end = q_r.scan_end;
  end

  // stage 4: bounds and row
  logic signed [SW-1:0] row;
  logic                 in_band;
  cell_t                o_next;

  always_comb begin
    row     = $signed(SW'(ROW_TOP)) - c_r.fy;
    in_band = c_r.ok &&
              (c_r.cx >= 0) && (c_r.cx < $signed(SW'(GRID_DIM))) &&
              (c_r.fy >= $signed(SW'(cfg.near_limit))) &&
              (c_r.fy < $signed(SW'(cfg.far_limit))) &&
              (row >= 0) && (row < $signed(SW'(GRID_DIM)));
    o_next.hit       = in_band;
    o_next.cell_col  = in_band ? c_r.cx[CELL_W-1:0] : '0;
    o_next.cell_row  = in_band ? row[CELL_W-1:0] : '0;
    o_next.scan_done = c_r.scan_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) valid[0] <= in_valid;
      if (load[1]) valid[1] <= valid[0];
      if (load[2]) valid[2] <= valid[1];
      if (load[3]) valid[3] <= valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) m_r      <= m_next;
    if (load[1]) q_r      <= q_next;
    if (load[2]) c_r      <= c_next;
    if (load[3]) out_item <= o_next;
  end

endmodule
`default_nettype wire

FILE: sv/lidar_beam_to_grid_cell_top.sv
// Lidar beam to occupancy grid cell: top level with configuration registers.
// Accepts one beam per clock unless a stalled output has filled every stage, and
// returns one result per beam, in order, through two front stages for the angle
// multiply and start vector, one register per CORDIC micro-rotation, and four
// stages for the scale by ten, sign, bounds and row mapping. A stalled output
// freezes only the filled stages; bubbles further up the pipeline still advance
// and new beams are taken until every stage holds an item. Configuration writes
// are always ready and must happen while idle.
`default_nettype none
module lidar_beam_to_grid_cell_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lbg_pkg::beam_t              in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lbg_pkg::cell_t              out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lbg_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DW-1:0]  cfg_data
);
  import lbg_pkg::*;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start       <= 16'd0;
      cfg.angle_step        <= 16'd0;
      cfg.range_floor_mm    <= 16'd20;
      cfg.range_ceiling_mm  <= 16'd30000;
      cfg.origin_col        <= 10'd500;
      cfg.origin_row_offset <= 11'sd130;
      cfg.near_limit        <= 10'd0;
      cfg.far_limit         <= 11'd400;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ANGLE_START:       cfg.angle_start       <= cfg_data;
        CFG_ANGLE_STEP:        cfg.angle_step        <= cfg_data;
        CFG_RANGE_FLOOR_MM:    cfg.range_floor_mm    <= cfg_data;
        CFG_RANGE_CEILING_MM:  cfg.range_ceiling_mm  <= cfg_data;
        CFG_ORIGIN_COL:        cfg.origin_col        <= cfg_data[9:0];
        CFG_ORIGIN_ROW_OFFSET: cfg.origin_row_offset <= $signed(cfg_data[10:0]);
        CFG_NEAR_LIMIT:        cfg.near_limit        <= cfg_data[9:0];
        CFG_FAR_LIMIT:         cfg.far_limit         <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic [PIPE_STAGES-1:0] v_all;
  logic [PIPE_STAGES-1:0] en;

  // a stage advances when the output drains or any stage at or after it is empty
  always_comb begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      en[k] = !out_stall ||
              !(&(v_all | PIPE_STAGES'((64'(1) << k) - 64'(1))));
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_all[PIPE_STAGES-1];

  logic [FRONT_STAGES-1:0]  front_v;
  logic [CORDIC_STAGES-1:0] cordic_v;
  logic [CELL_STAGES-1:0]   cell_v;
  rot_t                     front_rot;
  rot_t                     cordic_rot;

  assign v_all = {cell_v, cordic_v, front_v};

  lbg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .load     (en[FRONT_STAGES-1:0]),
    .in_valid (in_valid),
    .in_item  (in_item),
    .valid    (front_v),
    .out_rot  (front_rot)
  );

  lbg_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .load     (en[FRONT_STAGES +: CORDIC_STAGES]),
    .in_valid (front_v[FRONT_STAGES-1]),
    .in_rot   (front_rot),
    .valid    (cordic_v),
    .out_rot  (cordic_rot)
  );

  lbg_cell u_cell (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .load     (en[FRONT_STAGES+CORDIC_STAGES +: CELL_STAGES]),
    .in_valid (cordic_v[CORDIC_STAGES-1]),
    .in_rot   (cordic_rot),
    .valid    (cell_v),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

FILE: sv/lbg_checker.sv
// Port-level checks for the beam-to-grid block, bound to the top level.
`default_nettype none
`include "lidar_beam_to_grid_cell_top_macros.svh"
module lbg_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input lbg_pkg::cell_t out_item
);
  import lbg_pkg::*;

  // held result stays put
  `LBG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item))
  // rejected beams report a zero cell
  `LBG_ASSERT_IMPL(a_miss_zero, clk, rst, out_valid && !out_item.hit, out_item.cell_col == '0 && out_item.cell_row == '0)
  // forward coordinate is never negative on a hit, so the row stays below the margin
  `LBG_ASSERT_IMPL(a_row_band, clk, rst, out_valid && out_item.hit, out_item.cell_row <= CELL_W'(ROW_TOP))
  // input backs up only behind a blocked output
  `LBG_ASSERT_IMPL(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

endmodule

bind lidar_beam_to_grid_cell_top lbg_checker u_lbg_checker (.*);
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the lidar beam to grid cell projection block.
module tb;
  import lbg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 160;
  localparam int DRAIN_CYCLES = 2 * PIPE_STAGES + 8;
  localparam int MAX_SHOWN = 40;
  localparam int ROT_ENTRIES = 24;
  localparam longint BEAM_GAIN = 64'sd39796;
  localparam longint RANGE_MARGIN_MM = 64'sd100;
  localparam longint Q16_CELL = 64'sd655360;
  localparam longint QUARTER_TURN_Q32 = 64'sd1073741824;
  localparam longint HALF_TURN_Q32 = 64'sd2147483648;
  localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 4'd15;

  // micro-rotation angles, 2^32 per turn
  localparam longint ROT_ANGLE [ROT_ENTRIES] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  typedef struct packed {
    logic [15:0]        angle_start;
    logic [15:0]        angle_step;
    logic [15:0]        floor_mm;
    logic [15:0]        ceiling_mm;
    logic [9:0]         origin_col;
    logic signed [10:0] row_offset;
    logic [9:0]         near_limit;
    logic [10:0]        far_limit;
  } grid_setup_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  beam_t             in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cell_t             out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  beam_t       beam_backlog[$];
  cell_t       pending_cells[$];
  grid_setup_t setup;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  bit          beam_taken = 1'b0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  lidar_beam_to_grid_cell_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic cell_t project_beam(beam_t b, grid_setup_t s);
    cell_t       res;
    logic [15:0] turn16;
    longint      rng, floor_mm, ceil_mm, x, y, z, dx, dy, cx, fy, rw;
    res = '0;
    res.scan_done = b.scan_end;
    rng = longint'(b.range_mm);
    floor_mm = longint'(s.floor_mm);
    ceil_mm = longint'(s.ceiling_mm) - RANGE_MARGIN_MM;
    if (int'(b.beam_index) < MAX_BEAMS && rng > floor_mm && rng < ceil_mm) begin
      turn16 = s.angle_start + b.beam_index * s.angle_step;
      z = longint'($signed(turn16)) * 65536;
      x = rng * BEAM_GAIN;
      y = 0;
      // fold into +-90 degrees by a half turn
      if (z > QUARTER_TURN_Q32) begin
        z -= HALF_TURN_Q32;
        x = -x;
      end else if (z < -QUARTER_TURN_Q32) begin
        z += HALF_TURN_Q32;
        x = -x;
      end
      for (int i = 0; i < CORDIC_STAGES && i < ROT_ENTRIES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ROT_ANGLE[i];
        end else begin
          x += dx;
          y -= dy;
          z += ROT_ANGLE[i];
        end
      end
      // beam point is (-y, x) in Q16 mm
      cx = (-y + longint'(s.origin_col) * Q16_CELL) / Q16_CELL;
      fy = (x + longint'(s.row_offset) * Q16_CELL) / Q16_CELL;
      if (cx >= 0 && cx < GRID_DIM && fy >= longint'(s.near_limit) &&
          fy < longint'(s.far_limit)) begin
        rw = GRID_DIM - ROW_MARGIN - 1 - fy;
        if (rw >= 0 && rw < GRID_DIM) begin
          res.hit = 1'b1;
          res.cell_col = cx[9:0];
          res.cell_row = rw[9:0];
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endtask

  // Register shadow, updated on each accepted write request.
  always @(posedge clk) begin
    if (rst) begin
      setup.angle_start <= 16'd0;
      setup.angle_step <= 16'd0;
      setup.floor_mm <= 16'd20;
      setup.ceiling_mm <= 16'd30000;
      setup.origin_col <= 10'd500;
      setup.row_offset <= 11'sd130;
      setup.near_limit <= 10'd0;
      setup.far_limit <= 11'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ANGLE_START:       setup.angle_start <= cfg_data;
        CFG_ANGLE_STEP:        setup.angle_step <= cfg_data;
        CFG_RANGE_FLOOR_MM:    setup.floor_mm <= cfg_data;
        CFG_RANGE_CEILING_MM:  setup.ceiling_mm <= cfg_data;
        CFG_ORIGIN_COL:        setup.origin_col <= cfg_data[9:0];
        CFG_ORIGIN_ROW_OFFSET: setup.row_offset <= cfg_data[10:0];
        CFG_NEAR_LIMIT:        setup.near_limit <= cfg_data[9:0];
        CFG_FAR_LIMIT:         setup.far_limit <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Predict the cell of every accepted beam request.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      pending_cells.push_back(project_beam(in_item, setup));
      beam_taken = 1'b1;
    end
  end

  // Hold the request until it is taken; then advance or idle.
  always @(negedge clk) begin
    if (!rst && (!in_valid || beam_taken)) begin
      if (beam_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= beam_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    beam_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req <= 1'b0;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : cell_monitor
    cell_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        report_mismatch("result with no beam pending");
      end else begin
        want = pending_cells.pop_front();
        if (out_item.hit !== want.hit)
          report_mismatch($sformatf("hit got %0b want %0b", out_item.hit, want.hit));
        if (out_item.cell_col !== want.cell_col)
          report_mismatch($sformatf("cell_col got %0d want %0d",
                                    out_item.cell_col, want.cell_col));
        if (out_item.cell_row !== want.cell_row)
          report_mismatch($sformatf("cell_row got %0d want %0d",
                                    out_item.cell_row, want.cell_row));
        if (out_item.scan_done !== want.scan_done)
          report_mismatch($sformatf("scan_done got %0b want %0b",
                                    out_item.scan_done, want.scan_done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lidar_beam_to_grid_cell_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic close_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_setup(logic [15:0] a_start, logic [15:0] a_step,
                               logic [15:0] floor_w, logic [15:0] ceil_w,
                               logic [15:0] col_w, logic [15:0] row_w,
                               logic [15:0] near_w, logic [15:0] far_w);
    write_reg(CFG_ANGLE_START, a_start);
    write_reg(CFG_ANGLE_STEP, a_step);
    write_reg(CFG_RANGE_FLOOR_MM, floor_w);
    write_reg(CFG_RANGE_CEILING_MM, ceil_w);
    write_reg(CFG_ORIGIN_COL, col_w);
    write_reg(CFG_ORIGIN_ROW_OFFSET, row_w);
    write_reg(CFG_NEAR_LIMIT, near_w);
    write_reg(CFG_FAR_LIMIT, far_w);
    close_writes();
  endtask

  // Random geometry; junk in the unused upper bits checks the masking.
  task automatic program_random_setup();
    int near_v;
    near_v = $urandom_range(300);
    write_reg(CFG_ANGLE_START, 16'($urandom));
    write_reg(CFG_ANGLE_STEP,
              $urandom_range(1) ? 16'($urandom_range(256)) : 16'($urandom));
    write_reg(CFG_RANGE_FLOOR_MM, 16'($urandom_range(200)));
    write_reg(CFG_RANGE_CEILING_MM, 16'($urandom_range(65535, 1500)));
    write_reg(CFG_ORIGIN_COL, {6'($urandom), 10'($urandom_range(900, 100))});
    write_reg(CFG_ORIGIN_ROW_OFFSET, {5'($urandom), 11'($urandom_range(600) - 300)});
    write_reg(CFG_NEAR_LIMIT, {6'($urandom), 10'(near_v)});
    write_reg(CFG_FAR_LIMIT, {5'($urandom), 11'($urandom_range(1024, near_v))});
    close_writes();
  endtask

  task automatic add_beam(int rng, int idx, bit last);
    beam_t b;
    b.range_mm = 16'(rng);
    b.beam_index = 10'(idx);
    b.scan_end = last;
    beam_backlog.push_back(b);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (beam_backlog.size() != 0 || in_valid || pending_cells.size() != 0);
  endtask

  task automatic run_random(int count, int send_pct, int recv_pct, bit squeeze);
    beam_t b;
    int    lo, hi, pick;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) hold_req = 1'b1;
    lo = int'(setup.floor_mm) + 1;
    hi = int'(setup.ceiling_mm) - 101;
    repeat (count) begin
      pick = $urandom_range(99);
      if (hi < lo || pick < 15) begin
        b.range_mm = 16'($urandom);
      end else if (pick < 25) begin
        case ($urandom_range(3))
          0: b.range_mm = 16'(lo - 1);
          1: b.range_mm = 16'(lo);
          2: b.range_mm = 16'(hi);
          default: b.range_mm = 16'(hi + 1);
        endcase
      end else if (pick < 75) begin
        // short ranges land inside the grid most often
        b.range_mm = 16'($urandom_range((hi < lo + 5000) ? hi : lo + 5000, lo));
      end else begin
        b.range_mm = 16'($urandom_range(hi, lo));
      end
      b.beam_index = 10'($urandom);
      b.scan_end = ($urandom_range(15) == 0);
      beam_backlog.push_back(b);
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // writes to unlisted indexes must leave every register alone
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    // one beam per 1/1024 turn
    program_setup(16'd0, 16'd64, 16'd20, 16'd30000, 16'd500, 16'd130, 16'd0, 16'd400);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_beam(0, 0, 1'b0);
    add_beam(20, 0, 1'b0);
    add_beam(21, 0, 1'b0);
    add_beam(29899, 0, 1'b0);
    add_beam(29900, 0, 1'b1);
    add_beam(65535, 1023, 1'b0);
    add_beam(1000, 0, 1'b0);
    add_beam(1000, 256, 1'b0);
    add_beam(1000, 512, 1'b0);
    add_beam(1000, 768, 1'b1);
    add_beam(1000, 255, 1'b0);
    add_beam(1000, 257, 1'b0);
    add_beam(1000, 767, 1'b0);
    add_beam(1000, 769, 1'b0);
    add_beam(1000, 1023, 1'b1);
    add_beam(6000, 256, 1'b0);
    add_beam(6000, 768, 1'b0);
    add_beam(2000, 512, 1'b0);
    add_beam(2700, 0, 1'b0);
    add_beam(2690, 0, 1'b1);
    wait_drained();

    // widest band, sensor on the last column, most negative row offset
    program_setup(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0400, 16'd0, 16'd1024);
    add_beam(20400, 1, 1'b0);
    add_beam(20300, 1, 1'b0);
    add_beam(19000, 1, 1'b1);
    run_random(150, 0, 0, 1'b0);

    program_random_setup();
    run_random(300, 60, 0, 1'b0);
    program_random_setup();
    run_random(300, 0, 60, 1'b0);
    program_random_setup();
    run_random(300, 12, 12, 1'b1);

    // nothing can pass: floor at top, ceiling at zero, empty forward band
    program_setup(16'h7FFF, 16'h8000, 16'hFFFF, 16'd0, 16'd0, 16'h03FF, 16'hFFFF, 16'd0);
    run_random(60, 12, 12, 1'b0);

    // ceiling below the guard band
    program_setup(16'd0, 16'd1, 16'd0, 16'd99, 16'd500, 16'd130, 16'd0, 16'd400);
    run_random(60, 0, 60, 1'b0);

    program_random_setup();
    run_random(280, 0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_cells.size() == 0)
      $display("lidar_beam_to_grid_cell_top verification clean");
    else
      $display("lidar_beam_to_grid_cell_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lbg_pkg.sv
sv/lbg_front.sv
sv/lbg_cordic.sv
sv/lbg_cell.sv
sv/lidar_beam_to_grid_cell_top.sv
sv/lbg_checker.sv
tb/sv/tb.sv
